### rtl/cpve_pkg.sv
// ----------------------------------------------------------------------------
// cpve_pkg
// Shared types, limits and the power-of-three table for the parity engine.
// ----------------------------------------------------------------------------
package cpve_pkg;

	localparam int DIGIT_W = 5;
	localparam int STEP_W  = 6;
	localparam int MASK_W  = 23;
	localparam int X_W     = 38;
	localparam int VAL_W   = 40;
	localparam int N_W     = 64;
	localparam int EXP_W   = 6;

	localparam logic [DIGIT_W-1:0] MAX_DIGITS = 5'd23;
	localparam logic [STEP_W-1:0]  MAX_STEPS  = 6'd40;

	localparam logic REG_DIGIT_COUNT = 1'b0;
	localparam logic REG_STEP_COUNT  = 1'b1;

	localparam logic [DIGIT_W-1:0] DIGIT_COUNT_RST = 5'd20;
	localparam logic [STEP_W-1:0]  STEP_COUNT_RST  = 6'd35;

	localparam logic [N_W-1:0] POW3 [0:40] = '{
		64'd1, 64'd3, 64'd9, 64'd27, 64'd81, 64'd243, 64'd729, 64'd2187, 64'd6561,
		64'd19683, 64'd59049, 64'd177147, 64'd531441, 64'd1594323, 64'd4782969,
		64'd14348907, 64'd43046721, 64'd129140163, 64'd387420489, 64'd1162261467,
		64'd3486784401, 64'd10460353203, 64'd31381059609, 64'd94143178827,
		64'd282429536481, 64'd847288609443, 64'd2541865828329, 64'd7625597484987,
		64'd22876792454961, 64'd68630377364883, 64'd205891132094649,
		64'd617673396283947, 64'd1853020188851841, 64'd5559060566555523,
		64'd16677181699666569, 64'd50031545098999707, 64'd150094635296999121,
		64'd450283905890997363, 64'd1350851717672992089, 64'd4052555153018976267,
		64'd12157665459056928801
	};

	function automatic logic [N_W-1:0] pow3(input logic [EXP_W-1:0] e);
		logic [N_W-1:0] r;
		r = '0;
		if (e <= 6'd40) begin
			r = POW3[e];
		end
		return r;
	endfunction

	typedef struct packed {
		logic               load;
		logic               add;
		logic               prep;
		logic               walk;
		logic               publish;
		logic [DIGIT_W-1:0] digit_idx;
		logic [STEP_W-1:0]  step_idx;
	} dp_cmd_t;

endpackage

### rtl/cpve_ctrl.sv
// ----------------------------------------------------------------------------
// cpve_ctrl
// Sequencer: digit accumulation, map walk and result hand-off.
// ----------------------------------------------------------------------------
module cpve_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	output logic                           out_valid,
	input  logic                           out_stall,
	input  logic [cpve_pkg::DIGIT_W-1:0]   digits,
	input  logic [cpve_pkg::STEP_W-1:0]    steps,
	output cpve_pkg::dp_cmd_t              cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_PREP,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [cpve_pkg::DIGIT_W-1:0]   idx_q;
	logic [cpve_pkg::STEP_W-1:0]    k_q;
	logic                           out_valid_q;
	logic                           accept;
	logic                           publish;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign publish   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.add       = (state_q == ST_SUM);
		cmd.prep      = (state_q == ST_PREP);
		cmd.walk      = (state_q == ST_WALK);
		cmd.publish   = publish;
		cmd.digit_idx = idx_q;
		cmd.step_idx  = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					idx_q <= idx_q + 5'd1;
					if (idx_q == digits - 5'd1) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					k_q     <= 6'd1;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					k_q <= k_q + 6'd1;
					if (k_q == steps) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/cpve_dp.sv
// ----------------------------------------------------------------------------
// cpve_dp
// Datapath: ternary digit sum, shortcut map step unit and result register.
// ----------------------------------------------------------------------------
module cpve_dp (
	input  logic                           clk,
	input  cpve_pkg::dp_cmd_t              cmd,
	input  logic [cpve_pkg::DIGIT_W-1:0]   digits,
	input  logic [cpve_pkg::MASK_W-1:0]    digit_mask,
	output logic [cpve_pkg::VAL_W-1:0]     start_value,
	output logic [cpve_pkg::VAL_W-1:0]     parity_vec,
	output logic [cpve_pkg::STEP_W-1:0]    odd_count,
	output logic [cpve_pkg::STEP_W-1:0]    alive_steps
);

	logic [cpve_pkg::MASK_W-1:0]  mask_q;
	logic [cpve_pkg::X_W-1:0]     x_q;
	logic [cpve_pkg::N_W-1:0]     n_q;
	logic [cpve_pkg::VAL_W-1:0]   start_q;
	logic [cpve_pkg::VAL_W-1:0]   parity_q;
	logic [cpve_pkg::STEP_W-1:0]  odd_q;
	logic                         alive_q;
	logic [cpve_pkg::STEP_W-1:0]  alive_len_q;

	logic [cpve_pkg::VAL_W-1:0]   start_out_q;
	logic [cpve_pkg::VAL_W-1:0]   parity_out_q;
	logic [cpve_pkg::STEP_W-1:0]  odd_out_q;
	logic [cpve_pkg::STEP_W-1:0]  alive_out_q;

	logic [cpve_pkg::N_W-1:0]     top_pow;
	logic [cpve_pkg::N_W-1:0]     digit_pow;
	logic [cpve_pkg::STEP_W-1:0]  odd_nx;
	logic [cpve_pkg::N_W-1:0]     n_nx;
	logic [cpve_pkg::N_W-1:0]     odd_pow;
	logic                         still_alive;
	logic [cpve_pkg::VAL_W-1:0]   parity_hit;

	assign top_pow     = cpve_pkg::pow3({1'b0, digits});
	assign digit_pow   = cpve_pkg::pow3({1'b0, cmd.digit_idx});
	assign odd_nx      = odd_q + {5'd0, n_q[0]};
	assign n_nx        = n_q[0] ? (n_q + (n_q >> 1) + 64'd1) : (n_q >> 1);
	assign odd_pow     = cpve_pkg::pow3(odd_nx);
	assign still_alive = alive_q && ((odd_pow >> cmd.step_idx) != '0);
	assign parity_hit  = {39'd0, n_q[0]} << (cmd.step_idx - 6'd1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mask_q <= digit_mask;
			x_q    <= top_pow[cpve_pkg::X_W-1:0];
		end
		if (cmd.add && mask_q[cmd.digit_idx]) begin
			x_q <= x_q + digit_pow[cpve_pkg::X_W-1:0];
		end
		if (cmd.prep) begin
			start_q     <= {x_q, 2'b11};
			n_q         <= {24'd0, x_q, 2'b11};
			parity_q    <= '0;
			odd_q       <= '0;
			alive_q     <= 1'b1;
			alive_len_q <= '0;
		end
		if (cmd.walk) begin
			n_q      <= n_nx;
			parity_q <= parity_q | parity_hit;
			odd_q    <= odd_nx;
			alive_q  <= still_alive;
			if (still_alive) begin
				alive_len_q <= cmd.step_idx;
			end
		end
		if (cmd.publish) begin
			start_out_q  <= start_q;
			parity_out_q <= parity_q;
			odd_out_q    <= odd_q;
			alive_out_q  <= alive_len_q;
		end
	end

	assign start_value = start_out_q;
	assign parity_vec  = parity_out_q;
	assign odd_count   = odd_out_q;
	assign alive_steps = alive_out_q;

endmodule

### rtl/collatz_parity_vector_engine.sv
// ----------------------------------------------------------------------------
// collatz_parity_vector_engine
// Forms 4X+3 from a ternary digit mask and records its shortcut Collatz
// parity vector, odd-step count and leading run where 3^odd >= 2^step.
// ----------------------------------------------------------------------------
// One item at a time. An accepted mask passes through the digit adder
// (one power of three per cycle, m digits), the start-value step, the single
// map-step unit (H steps) and the hand-off of the result to the output
// register, which waits while a held result is stalled at the output; m and
// H are the clamped digit_count and step_count.
// A finished result waits in the output register while the next mask is
// taken.
// ----------------------------------------------------------------------------
module collatz_parity_vector_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_index,
	input  logic [cpve_pkg::STEP_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [cpve_pkg::MASK_W-1:0]    digit_mask,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cpve_pkg::VAL_W-1:0]     start_value,
	output logic [cpve_pkg::VAL_W-1:0]     parity_vec,
	output logic [cpve_pkg::STEP_W-1:0]    odd_count,
	output logic [cpve_pkg::STEP_W-1:0]    alive_steps
);

	logic [cpve_pkg::DIGIT_W-1:0]  digit_count_q;
	logic [cpve_pkg::STEP_W-1:0]   step_count_q;
	logic [cpve_pkg::DIGIT_W-1:0]  digits;
	logic [cpve_pkg::STEP_W-1:0]   steps;
	cpve_pkg::dp_cmd_t             cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= cpve_pkg::DIGIT_COUNT_RST;
			step_count_q  <= cpve_pkg::STEP_COUNT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cpve_pkg::REG_DIGIT_COUNT: digit_count_q <= cfg_data[cpve_pkg::DIGIT_W-1:0];
				cpve_pkg::REG_STEP_COUNT:  step_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (digit_count_q == '0) begin
			digits = 5'd1;
		end else if (digit_count_q > cpve_pkg::MAX_DIGITS) begin
			digits = cpve_pkg::MAX_DIGITS;
		end else begin
			digits = digit_count_q;
		end
		priority if (step_count_q == '0) begin
			steps = 6'd1;
		end else if (step_count_q > cpve_pkg::MAX_STEPS) begin
			steps = cpve_pkg::MAX_STEPS;
		end else begin
			steps = step_count_q;
		end
	end

	cpve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digits    (digits),
		.steps     (steps),
		.cmd       (cmd)
	);

	cpve_dp u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.digits      (digits),
		.digit_mask  (digit_mask),
		.start_value (start_value),
		.parity_vec  (parity_vec),
		.odd_count   (odd_count),
		.alive_steps (alive_steps)
	);

endmodule
